// File: sv/drnp_pkg.sv
// Shared types and constants of the delimited radix number parser.
`default_nettype none

package drnp_pkg;

	// Radix selection held in the radix_mode register.
	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	// Register index of radix_mode on the configuration port.
	localparam logic REG_RADIX_MODE = 1'b0;

	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;

	localparam logic [3:0] MAX_OCT_DIGIT = 4'd7;
	localparam logic [3:0] MAX_BIN_DIGIT = 4'd1;
	localparam logic [3:0] LETTER_BASE   = 4'd10;

	// Decoded character.
	typedef struct packed {
		logic       legal;
		logic [3:0] value;
	} digit_t;

	// One finished word.
	typedef struct packed {
		logic [15:0] number;
		logic        invalid;
		logic        last;
	} word_result_t;

endpackage

`default_nettype wire

// File: sv/drnp_digit.sv
// Character to digit decoder for the configured radix.
`default_nettype none

module drnp_digit
	import drnp_pkg::*;
(
	input  wire logic [7:0] char_code,
	input  wire radix_t     radix,
	output digit_t          digit
);

	logic       is_dec;
	logic       is_lower;
	logic       is_upper;
	logic [3:0] raw_value;

	always_comb begin
		is_dec   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
		is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);

		priority if (is_dec) begin
			raw_value = 4'(char_code - CHAR_ZERO);
		end else if (is_lower) begin
			raw_value = 4'(char_code - CHAR_LOWER_A) + LETTER_BASE;
		end else begin
			raw_value = 4'(char_code - CHAR_UPPER_A) + LETTER_BASE;
		end

		unique case (radix)
			RADIX_DEC: digit.legal = is_dec;
			RADIX_HEX: digit.legal = is_dec || is_lower || is_upper;
			RADIX_OCT: digit.legal = is_dec && (raw_value <= MAX_OCT_DIGIT);
			RADIX_BIN: digit.legal = is_dec && (raw_value <= MAX_BIN_DIGIT);
			default:   digit.legal = 1'b0;
		endcase
		digit.value = raw_value;
	end

endmodule

`default_nettype wire

// File: sv/drnp_word.sv
// Word state: Horner accumulation, digit count, illegal-digit flag and word result.
`default_nettype none

module drnp_word
	import drnp_pkg::*;
#(
	parameter int MAX_DIGITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_code,
	input  wire logic       final_char,
	input  wire radix_t     radix,
	input  wire digit_t     digit,
	output logic            emit,
	output word_result_t    result
);

	localparam int CntW = $clog2(MAX_DIGITS + 1);

	logic [15:0]     acc_q;
	logic [CntW-1:0] count_q;
	logic            bad_q;

	logic            is_delim;
	logic            keep;
	logic [15:0]     acc_scaled;
	logic [15:0]     acc_next;
	logic            bad_next;

	always_comb begin
		is_delim = (char_code == CHAR_COMMA) || (char_code == CHAR_SPACE);
		// The final character is always kept, delimiter or not, up to the length limit.
		keep     = (final_char || !is_delim) && (count_q < CntW'(MAX_DIGITS));
		emit     = final_char || is_delim;

		unique case (radix)
			RADIX_DEC: acc_scaled = (acc_q << 3) + (acc_q << 1);
			RADIX_HEX: acc_scaled = acc_q << 4;
			RADIX_OCT: acc_scaled = acc_q << 3;
			RADIX_BIN: acc_scaled = acc_q << 1;
			default:   acc_scaled = acc_q;
		endcase

		acc_next = acc_q;
		bad_next = bad_q;
		if (keep) begin
			if (digit.legal) begin
				acc_next = acc_scaled + {12'd0, digit.value};
			end else begin
				bad_next = 1'b1;
			end
		end

		result.invalid = bad_next;
		result.number  = bad_next ? 16'd0 : acc_next;
		result.last    = final_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
		end else if (step) begin
			if (emit) begin
				acc_q   <= '0;
				count_q <= '0;
				bad_q   <= 1'b0;
			end else if (keep) begin
				acc_q   <= acc_next;
				count_q <= count_q + CntW'(1);
				bad_q   <= bad_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/delimited_radix_number_parser_top.sv
// Top level of the delimited radix number parser: ports, register, input and result stages.
`default_nettype none

// The parser takes one ASCII character per input item (s_tdata), with s_tlast
// marking the final character of a string, and splits the stream into words at
// commas and spaces. Each word ends in one result item carrying the 16-bit
// value in the radix chosen by the radix_mode register at byte address 0
// (0 decimal, 1 hexadecimal, 2 octal, 3 binary), an invalid flag in m_tuser
// and m_tlast set for the word closed by the final character. The final
// character joins the last word (within MAX_DIGITS), so a trailing comma or space
// there counts as an illegal digit. A word with an illegal digit returns 0 with
// invalid set; an empty word returns 0 with invalid clear; values wrap modulo
// 2^16 and characters past MAX_DIGITS in a word are ignored. One character is
// taken every clock cycle unless m_tready holds a result back: an item is
// captured in the input stage register, then the word state and the result are
// updated by shift-and-add logic and the result is written to the output
// register. The sustained rate is one item per cycle and is set by the single
// accumulator update loop; it drops only while m_tready holds a result back.
// The radix register should be written only while no word is in flight.

module delimited_radix_number_parser_top
	import drnp_pkg::*;
#(
	parameter int MAX_DIGITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,

	// Character input.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // final_char

	// Word results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] number
	output logic             m_tuser,   // [0] invalid
	output logic             m_tlast    // last
);

	radix_t       radix_q;

	logic         in_valid_s1;
	logic [7:0]   char_s1;
	logic         final_s1;

	logic         out_valid_q;
	word_result_t out_q;

	digit_t       digit;
	logic         emit;
	word_result_t result;

	logic         out_free;
	logic         step;

	// The register index is the word address; low address bits are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIX_MODE) ? {30'd0, radix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_DEC;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX_MODE)) begin
			radix_q <= radix_t'(pwdata[1:0]);
		end
	end

	// The item in the input stage is consumed when it makes no result or when
	// the result register is free or being emptied this cycle.
	assign out_free = !out_valid_q || m_tready;
	assign step     = in_valid_s1 && (!emit || out_free);
	assign s_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	drnp_digit u_digit (
		.char_code (char_s1),
		.radix     (radix_q),
		.digit     (digit)
	);

	drnp_word #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_word (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.char_code  (char_s1),
		.final_char (final_s1),
		.radix      (radix_q),
		.digit      (digit),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.number;
	assign m_tuser  = out_q.invalid;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire
